/* rtl/fcbb_pkg.sv */
// shared types and constants for the frame change bounding box block
// no dependencies; imported by every module under rtl

`default_nettype none

package fcbb_pkg;

  // default coordinate width, range 8 to 16
  localparam int COORD_BITS_DEF = 16;

  // configuration register width and index width
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HIT_MODE     = 8'd2;

  // hit test modes
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_CHANGED     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SOLID       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOLID_CLEAR = 2'd2;

  // payload widths
  localparam int BYTE_W  = 8;
  localparam int IN_W    = 4 * BYTE_W;
  localparam int FIELD_W = 16;
  localparam int OUT_W   = 4 * FIELD_W;

  // one classified pixel handed from the input stage to the tracker
  typedef struct packed {
    logic valid;
    logic hit;
  } pix_t;

  // one finished bounding box handed from the tracker to the output register
  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] y_size;
    logic [FIELD_W-1:0] y_offset;
    logic [FIELD_W-1:0] x_size;
    logic [FIELD_W-1:0] x_offset;
  } box_t;

endpackage

`default_nettype wire

/* rtl/fcbb_in_stage.sv */
// input register of the frame change bounding box block: classifies each pixel
// as it is taken and holds the hit flag; depends on fcbb_pkg

`default_nettype none

module fcbb_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [fcbb_pkg::IN_W-1:0]   s_tdata,
  input  wire logic [fcbb_pkg::MODE_W-1:0] hit_mode,
  input  wire logic                        advance,
  output fcbb_pkg::pix_t                   pix
);
  import fcbb_pkg::*;

  logic              valid;
  logic              hit;
  logic              hit_next;
  logic [BYTE_W-1:0] pixel_first;
  logic [BYTE_W-1:0] mask_first;
  logic [BYTE_W-1:0] pixel_second;
  logic [BYTE_W-1:0] mask_second;

  assign pixel_first  = s_tdata[BYTE_W-1:0];
  assign mask_first   = s_tdata[2*BYTE_W-1:BYTE_W];
  assign pixel_second = s_tdata[3*BYTE_W-1:2*BYTE_W];
  assign mask_second  = s_tdata[4*BYTE_W-1:3*BYTE_W];

  always_comb begin
    unique case (hit_mode)
      MODE_CHANGED:     hit_next = (pixel_first != pixel_second) || (mask_first != mask_second);
      MODE_SOLID:       hit_next = (mask_first != '0);
      MODE_SOLID_CLEAR: hit_next = (mask_first != '0) && (mask_second == '0);
      default:          hit_next = 1'b0;
    endcase
  end

  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hit <= hit_next;
    end
  end

  assign pix.valid = valid;
  assign pix.hit   = hit;

endmodule

`default_nettype wire

/* rtl/fcbb_tracker.sv */
// raster position counters and hit bounds of the frame change bounding box
// block, with the box computed on the last pixel; depends on fcbb_pkg

`default_nettype none

module fcbb_tracker #(
  parameter int COORD_BITS = fcbb_pkg::COORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [fcbb_pkg::CFG_W-1:0] frame_width,
  input  wire logic [fcbb_pkg::CFG_W-1:0] frame_height,
  input  wire fcbb_pkg::pix_t             pix,
  input  wire logic                       advance,
  output fcbb_pkg::box_t                  box
);
  import fcbb_pkg::*;

  localparam int SIZE_W = COORD_BITS + 1;

  logic [COORD_BITS-1:0] column_count;
  logic [COORD_BITS-1:0] row_count;
  logic [COORD_BITS-1:0] lo_col;
  logic [COORD_BITS-1:0] hi_col;
  logic [COORD_BITS-1:0] lo_row;
  logic [COORD_BITS-1:0] hi_row;
  logic                  any_hit;

  logic [COORD_BITS-1:0] lo_col_next;
  logic [COORD_BITS-1:0] hi_col_next;
  logic [COORD_BITS-1:0] lo_row_next;
  logic [COORD_BITS-1:0] hi_row_next;
  logic                  any_hit_next;

  logic [COORD_BITS-1:0] width_eff;
  logic [COORD_BITS-1:0] height_eff;
  logic [COORD_BITS-1:0] last_col;
  logic [COORD_BITS-1:0] last_row;
  logic                  row_end;
  logic                  frame_end;
  logic [SIZE_W-1:0]     x_span;
  logic [SIZE_W-1:0]     y_span;

  // zero size acts as one
  assign width_eff  = frame_width[COORD_BITS-1:0];
  assign height_eff = frame_height[COORD_BITS-1:0];
  assign last_col   = (width_eff == '0) ? '0 : width_eff - 1'b1;
  assign last_row   = (height_eff == '0) ? '0 : height_eff - 1'b1;

  // at or beyond the last index counts as the last one
  assign row_end   = (column_count >= last_col);
  assign frame_end = row_end && (row_count >= last_row);

  always_comb begin
    lo_col_next  = lo_col;
    hi_col_next  = hi_col;
    lo_row_next  = lo_row;
    hi_row_next  = hi_row;
    any_hit_next = any_hit;
    if (pix.hit) begin
      any_hit_next = 1'b1;
      if (!any_hit) begin
        lo_col_next = column_count;
        hi_col_next = column_count;
        lo_row_next = row_count;
        hi_row_next = row_count;
      end else begin
        if (column_count < lo_col) lo_col_next = column_count;
        if (column_count > hi_col) hi_col_next = column_count;
        if (row_count < lo_row)    lo_row_next = row_count;
        if (row_count > hi_row)    hi_row_next = row_count;
      end
    end
  end

  assign x_span = {1'b0, hi_col_next} - {1'b0, lo_col_next} + SIZE_W'(1);
  assign y_span = {1'b0, hi_row_next} - {1'b0, lo_row_next} + SIZE_W'(1);

  always_comb begin
    box.valid = advance && frame_end;
    if (any_hit_next) begin
      box.x_offset = FIELD_W'(lo_col_next);
      box.x_size   = FIELD_W'(x_span);
      box.y_offset = FIELD_W'(lo_row_next);
      box.y_size   = FIELD_W'(y_span);
    end else begin
      box.x_offset = '0;
      box.x_size   = '0;
      box.y_offset = '0;
      box.y_size   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      lo_col       <= '0;
      hi_col       <= '0;
      lo_row       <= '0;
      hi_row       <= '0;
      any_hit      <= 1'b0;
    end else if (advance) begin
      if (frame_end) begin
        column_count <= '0;
        row_count    <= '0;
        lo_col       <= '0;
        hi_col       <= '0;
        lo_row       <= '0;
        hi_row       <= '0;
        any_hit      <= 1'b0;
      end else begin
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
        lo_col  <= lo_col_next;
        hi_col  <= hi_col_next;
        lo_row  <= lo_row_next;
        hi_row  <= hi_row_next;
        any_hit <= any_hit_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/frame_change_bounding_box.sv */
// top level of the frame change bounding box block: config registers, input
// stage, tracker and output register; depends on fcbb_pkg, fcbb_in_stage, fcbb_tracker

// Takes one pixel position per transaction in raster order (left to right, top
// to bottom) and reports, on the frame's last pixel, the smallest rectangle that
// holds every hit pixel: first column and row plus columns and rows spanned, all
// zero when nothing in the frame hit. hit_mode picks the test: 0 pixel or mask
// differs between the two frames, 1 first mask nonzero, 2 first mask nonzero and
// second mask zero, 3 never hits. A frame size of zero acts as one; if the size
// is lowered mid-frame, a count at or past the new last index ends the row or
// frame at once. Rate: one pixel per cycle unless a pixel waits, as below. Two
// register stages: the input register takes the frame's last pixel, then the
// output register takes its box and raises m_tvalid. The input register classifies
// the pixel, the tracker updates counters and bounds, the output register holds
// the box; a pixel waits only while a finished box is held and m_tready is low.
// Configuration writes are accepted every cycle and are meant for idle periods.

`default_nettype none

module frame_change_bounding_box #(
  parameter int COORD_BITS = fcbb_pkg::COORD_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // pixel stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // pixel_first[7:0], mask_first[15:8], pixel_second[23:16], mask_second[31:24]
  input  wire logic [fcbb_pkg::IN_W-1:0]        s_tdata,
  // bounding box results
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // x_offset[15:0], x_size[31:16], y_offset[47:32], y_size[63:48]
  output logic [fcbb_pkg::OUT_W-1:0]            m_tdata,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fcbb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fcbb_pkg::CFG_W-1:0]       cfg_data
);
  import fcbb_pkg::*;

  // configuration registers
  logic [CFG_W-1:0]  frame_width;
  logic [CFG_W-1:0]  frame_height;
  logic [MODE_W-1:0] hit_mode;

  pix_t pix;
  box_t box;
  logic advance;

  // output register
  logic             out_valid;
  logic [OUT_W-1:0] out_data;

  // write channel never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(1);
      frame_height <= CFG_W'(1);
      hit_mode     <= MODE_CHANGED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_HIT_MODE:     hit_mode     <= cfg_data[MODE_W-1:0];
        default:          ;
      endcase
    end
  end

  // a pixel moves on once the output register is free or being drained
  assign advance = pix.valid && (!out_valid || m_tready);

  fcbb_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .hit_mode (hit_mode),
    .advance  (advance),
    .pix      (pix)
  );

  fcbb_tracker #(
    .COORD_BITS (COORD_BITS)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pix          (pix),
    .advance      (advance),
    .box          (box)
  );

  // hold the finished box until the downstream transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (box.valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (box.valid) begin
      out_data <= {box.y_size, box.y_offset, box.x_size, box.x_offset};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

`default_nettype wire

/* dv/fcbb_box_checker.sv */
// bounding box checker: follows the pixel, config and result channels, predicts
// each frame's box and compares it with the block's output
// depends on fcbb_pkg

module fcbb_box_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [fcbb_pkg::IN_W-1:0]        s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [fcbb_pkg::OUT_W-1:0]       m_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [fcbb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fcbb_pkg::CFG_W-1:0]       cfg_data,
  output int                               mismatches,
  output int                               boxes_outstanding
);
  import fcbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = COORD_BITS_DEF;

  // same packing as m_tdata, x_offset in the lowest bits
  typedef struct packed {
    logic [FIELD_W-1:0] y_size;
    logic [FIELD_W-1:0] y_offset;
    logic [FIELD_W-1:0] x_size;
    logic [FIELD_W-1:0] x_offset;
  } box_fields_t;

  logic [CFG_W-1:0]   width_q;
  logic [CFG_W-1:0]   height_q;
  logic [MODE_W-1:0]  mode_q;
  logic [COORD_W-1:0] col_pos;
  logic [COORD_W-1:0] row_pos;
  logic [COORD_W-1:0] left_col;
  logic [COORD_W-1:0] right_col;
  logic [COORD_W-1:0] top_row;
  logic [COORD_W-1:0] bottom_row;
  bit                 hit_seen;
  box_fields_t        boxes_due[$];
  int                 error_total = 0;

  assign mismatches = error_total;
  initial boxes_outstanding = 0;

  function automatic bit pixel_hits(input logic [IN_W-1:0] word);
    logic [BYTE_W-1:0] p1, m1, p2, m2;
    {m2, p2, m1, p1} = word;
    case (mode_q)
      MODE_CHANGED:     return (p1 != p2) || (m1 != m2);
      MODE_SOLID:       return m1 != '0;
      MODE_SOLID_CLEAR: return (m1 != '0) && (m2 == '0);
      default:          return 1'b0;
    endcase
  endfunction

  task automatic clear_bounds();
    col_pos    = '0;
    row_pos    = '0;
    left_col   = '0;
    right_col  = '0;
    top_row    = '0;
    bottom_row = '0;
    hit_seen   = 1'b0;
  endtask

  task automatic track_pixel(input logic [IN_W-1:0] word, output bit frame_done,
                             output box_fields_t box);
    logic [COORD_W-1:0] last_col;
    logic [COORD_W-1:0] last_row;
    // a size of zero behaves as one
    last_col = (width_q[COORD_W-1:0] == '0) ? '0 : width_q[COORD_W-1:0] - 1'b1;
    last_row = (height_q[COORD_W-1:0] == '0) ? '0 : height_q[COORD_W-1:0] - 1'b1;
    if (pixel_hits(word)) begin
      if (!hit_seen) begin
        left_col   = col_pos;
        right_col  = col_pos;
        top_row    = row_pos;
        bottom_row = row_pos;
        hit_seen   = 1'b1;
      end else begin
        if (col_pos < left_col) left_col = col_pos;
        if (col_pos > right_col) right_col = col_pos;
        if (row_pos < top_row) top_row = row_pos;
        if (row_pos > bottom_row) bottom_row = row_pos;
      end
    end
    frame_done = 1'b0;
    box = '0;
    if (col_pos >= last_col) begin
      if (row_pos >= last_row) begin
        frame_done = 1'b1;
        if (hit_seen) begin
          box.x_offset = left_col;
          box.x_size   = right_col - left_col + 1'b1;
          box.y_offset = top_row;
          box.y_size   = bottom_row - top_row + 1'b1;
        end
        clear_bounds();
      end else begin
        col_pos = '0;
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_total++;
    end
  endtask

  always @(posedge clk) begin
    box_fields_t fresh;
    box_fields_t want;
    box_fields_t got;
    bit          done;
    if (rst) begin
      width_q  = 16'd1;
      height_q = 16'd1;
      mode_q   = MODE_CHANGED;
      clear_bounds();
      boxes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_q = cfg_data;
          REG_FRAME_HEIGHT: height_q = cfg_data;
          REG_HIT_MODE:     mode_q = cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        track_pixel(s_tdata, done, fresh);
        if (done) boxes_due.push_back(fresh);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (boxes_due.size() == 0) begin
          $display("%0t: box expected none, got x_off %0d x_size %0d y_off %0d y_size %0d",
                   $time, got.x_offset, got.x_size, got.y_offset, got.y_size);
          error_total++;
        end else begin
          want = boxes_due.pop_front();
          check_field("x_offset", want.x_offset, got.x_offset);
          check_field("x_size", want.x_size, got.x_size);
          check_field("y_offset", want.y_offset, got.y_offset);
          check_field("y_size", want.y_size, got.y_size);
        end
      end
    end
    boxes_outstanding <= boxes_due.size();
  end

endmodule

/* dv/frame_change_bounding_box_test.sv */
// top of the frame change bounding box testbench: clock, reset, pixel and config
// stimulus, result backpressure and the verdict
// depends on fcbb_pkg, frame_change_bounding_box and fcbb_box_checker

module frame_change_bounding_box_test;
  import fcbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 5;
  // block has two register stages, leave some slack before touching registers
  localparam int DRAIN_CYCLES = 8;
  // watchdog limit, well above the slowest correct run
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 470;

  // mode 3 has no name in the package; it never hits
  localparam logic [MODE_W-1:0] MODE_NEVER = 2'd3;
  // an index that maps to no register, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'hFF;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_W-1:0]       m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  int mismatches;
  int boxes_outstanding;
  int cycle_count = 0;

  // idle rates in percent, changed per phase
  int send_gap_pct   = 11;
  int ready_drop_pct = 66;

  always #(CLK_PERIOD / 2) clk = ~clk;

  frame_change_bounding_box dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fcbb_box_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tdata           (s_tdata),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .boxes_outstanding (boxes_outstanding)
  );

  // result side backpressure, one decision per cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= ready_drop_pct);
  end

  // watchdog: a hung handshake or a missing box ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // s_tdata packing: pixel_first lowest, then mask_first, pixel_second, mask_second
  function automatic logic [IN_W-1:0] pack_pixel(input logic [BYTE_W-1:0] p1, m1, p2, m2);
    return {m2, p2, m1, p1};
  endfunction

  // random pixel that hits or stays quiet under the given mode; some pure noise too
  function automatic logic [IN_W-1:0] make_pixel(input logic [MODE_W-1:0] mode,
                                                 input bit want_hit);
    logic [BYTE_W-1:0] p1, m1, p2, m2;
    p1 = BYTE_W'($urandom_range(0, 255));
    m1 = BYTE_W'($urandom_range(0, 255));
    p2 = BYTE_W'($urandom_range(0, 255));
    m2 = BYTE_W'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) return pack_pixel(p1, m1, p2, m2);
    case (mode)
      MODE_CHANGED: begin
        // a quiet pixel matches in both frames
        if (!want_hit) begin
          p2 = p1;
          m2 = m1;
        end
      end
      MODE_SOLID: begin
        if (want_hit) m1 = BYTE_W'($urandom_range(1, 255));
        else m1 = '0;
      end
      MODE_SOLID_CLEAR: begin
        if (want_hit) begin
          m1 = BYTE_W'($urandom_range(1, 255));
          m2 = '0;
        end else if ($urandom_range(0, 1) == 0) begin
          m1 = '0;
        end else begin
          m2 = BYTE_W'($urandom_range(1, 255));
        end
      end
      default: ;
    endcase
    return pack_pixel(p1, m1, p2, m2);
  endfunction

  // one pixel transaction, with random idle cycles in front of it
  task automatic send_pixel(input logic [IN_W-1:0] word);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and let every box and every in-flight pixel drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (boxes_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write width, height and mode, optionally followed by a write to no register
  task automatic program_frame(input logic [CFG_W-1:0] width, height, mode_word,
                               input bit stray);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= width;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= height;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_HIT_MODE;
    cfg_data  <= mode_word;
    do @(posedge clk); while (!cfg_ready);
    if (stray) begin
      cfg_index <= REG_UNMAPPED;
      cfg_data  <= CFG_W'($urandom_range(0, 16'hFFFF));
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // random frames: mostly small and complete, a few larger, some cut short so
  // the next size change lands in the middle of a frame
  task automatic run_random(input int item_goal);
    int                sent;
    int                pick;
    int                pixels;
    int                density;
    logic [CFG_W-1:0]  width;
    logic [CFG_W-1:0]  height;
    logic [MODE_W-1:0] mode;
    logic [13:0]       spare;
    logic [CFG_W-1:0]  mode_word;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) width = '0;
      else if (pick < 3) width = CFG_W'($urandom_range(9, 40));
      else width = CFG_W'($urandom_range(1, 8));
      pick = $urandom_range(0, 19);
      if (pick == 0) height = '0;
      else if (pick < 3) height = CFG_W'($urandom_range(6, 12));
      else height = CFG_W'($urandom_range(1, 5));
      pick = $urandom_range(0, 9);
      case (pick % 3)
        0: mode = MODE_CHANGED;
        1: mode = MODE_SOLID;
        default: mode = MODE_SOLID_CLEAR;
      endcase
      if (pick == 9) mode = MODE_NEVER;
      // upper bits of the mode write must be dropped by the block
      spare = 14'($urandom_range(0, 14'h3FFF));
      mode_word = ($urandom_range(0, 3) == 0) ? {spare, mode} : {14'd0, mode};
      wait_idle();
      program_frame(width, height, mode_word, $urandom_range(0, 15) == 0);
      pixels = (width == '0 ? 1 : int'(width)) * (height == '0 ? 1 : int'(height));
      if ($urandom_range(0, 7) == 0) pixels = int'($urandom_range(1, pixels));
      case ($urandom_range(0, 3))
        0: density = 0;
        1: density = 5;
        2: density = 30;
        default: density = 100;
      endcase
      repeat (pixels) begin
        send_pixel(make_pixel(mode, $urandom_range(0, 99) < density));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, sender idles now and then, receiver often stalls ----

    // reset size is one pixel: an unchanged pixel gives an empty box,
    // a changed one a single pixel box
    send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(pack_pixel(8'hFF, 8'hFF, 8'h00, 8'hFF));

    // 3x2 frame, changed pixels: mask-only change in row 0, pixel-only in row 1
    wait_idle();
    program_frame(16'd3, 16'd2, {14'd0, MODE_CHANGED}, 1'b0);
    send_pixel(pack_pixel(8'h12, 8'h34, 8'h12, 8'h34));
    send_pixel(pack_pixel(8'h55, 8'hFF, 8'h55, 8'h00));
    send_pixel(pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(pack_pixel(8'hA5, 8'h5A, 8'hA5, 8'h5A));
    send_pixel(pack_pixel(8'h00, 8'h80, 8'hFF, 8'h80));

    // zero width and height act as one, solid mask test
    wait_idle();
    program_frame(16'd0, 16'd0, {14'd0, MODE_SOLID}, 1'b0);
    send_pixel(pack_pixel(8'hFF, 8'h00, 8'hFF, 8'hFF));
    send_pixel(pack_pixel(8'h00, 8'h80, 8'h00, 8'h00));

    // solid then transparent: only the second pixel qualifies
    wait_idle();
    program_frame(16'd2, 16'd2, {14'd0, MODE_SOLID_CLEAR}, 1'b0);
    send_pixel(pack_pixel(8'h3C, 8'hFF, 8'h3C, 8'h01));
    send_pixel(pack_pixel(8'h00, 8'h01, 8'hFF, 8'h00));
    send_pixel(pack_pixel(8'hFF, 8'h00, 8'hFF, 8'h00));
    send_pixel(pack_pixel(8'h7F, 8'h00, 8'h7F, 8'hFF));

    // unused mode never hits, even on pixels that differ everywhere;
    // upper mode bits set and a write to an unmapped index
    wait_idle();
    program_frame(16'd2, 16'd1, {14'h3FFF, MODE_NEVER}, 1'b1);
    send_pixel(pack_pixel(8'hFF, 8'hFF, 8'h00, 8'h00));
    send_pixel(pack_pixel(8'h00, 8'h01, 8'hFE, 8'h00));

    // shrink the frame mid-way: start 4x3, stop at row 1 column 2, then
    // switch to 2x2 so the next pixel closes both the row and the frame
    wait_idle();
    program_frame(16'd4, 16'd3, {14'd0, MODE_CHANGED}, 1'b0);
    send_pixel(pack_pixel(8'h11, 8'h11, 8'h11, 8'h11));
    send_pixel(pack_pixel(8'h22, 8'h22, 8'h22, 8'h22));
    send_pixel(pack_pixel(8'h33, 8'h33, 8'h33, 8'h33));
    send_pixel(pack_pixel(8'h44, 8'h44, 8'h45, 8'h44));
    send_pixel(pack_pixel(8'h55, 8'h55, 8'h55, 8'h55));
    send_pixel(pack_pixel(8'h66, 8'h66, 8'h66, 8'h67));
    wait_idle();
    program_frame(16'd2, 16'd2, {14'd0, MODE_CHANGED}, 1'b0);
    send_pixel(pack_pixel(8'h77, 8'h77, 8'h77, 8'h77));

    // ---- random part, three idle profiles ----
    run_random(PHASE_ITEMS);

    send_gap_pct   = 66;
    ready_drop_pct = 11;
    run_random(PHASE_ITEMS);

    send_gap_pct   = 0;
    ready_drop_pct = 0;
    run_random(PHASE_ITEMS);

    // every box must have come back, then a few quiet cycles for strays
    wait_idle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
